// ----- rtl/core/rfa_pkg.sv -----
`timescale 1ns / 1ps
package rfa_pkg;

  localparam int OperandWidth = 32;
  localparam int ValueWidth   = 64;
  localparam int QueueDepth   = 2;

  typedef enum logic [1:0] {
    ActAdd = 2'd0,
    ActSub = 2'd1,
    ActMul = 2'd2,
    ActDiv = 2'd3
  } action_e;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] num_a;
    logic signed [31:0] den_a;
    logic signed [31:0] num_b;
    logic signed [31:0] den_b;
  } in_t;

  typedef struct packed {
    logic               status;
    logic signed [63:0] result_num;
    logic signed [63:0] result_den;
  } out_t;

  // Classified item handed from the front to the back
  typedef struct packed {
    logic                  err;
    logic [ValueWidth-1:0] x;
    logic [ValueWidth-1:0] y;
  } job_t;

  // Divider response
  typedef struct packed {
    logic                  busy;
    logic                  done;
    logic [ValueWidth-1:0] quo;
    logic [ValueWidth-1:0] rem;
  } div_rsp_t;

  function automatic logic [ValueWidth-1:0] mag(input logic [ValueWidth-1:0] v);
    mag = v[ValueWidth-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [ValueWidth-1:0] negate_if(input logic neg,
                                                      input logic [ValueWidth-1:0] v);
    negate_if = neg ? (~v + 1'b1) : v;
  endfunction

endpackage

// ----- rtl/core/rfa_front.sv -----
`timescale 1ns / 1ps
module rfa_front #(
  parameter int OPERAND_WIDTH = rfa_pkg::OperandWidth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rfa_pkg::in_t  in_i,
  output logic          job_valid_o,
  input  logic          job_ready_i,
  output rfa_pkg::job_t job_o
);
  import rfa_pkg::*;

  localparam int PW = 2 * OPERAND_WIDTH;

  typedef enum logic [2:0] {
    FIdle = 3'b001,
    FMul  = 3'b010,
    FPush = 3'b100
  } fstate_e;

  fstate_e state_q, state_d;
  logic [1:0] step_q, step_d;
  logic signed [OPERAND_WIDTH-1:0] a_q, b_q, c_q, d_q;
  action_e act_q;
  logic err_q;
  logic signed [PW-1:0] p0_q, p1_q, p2_q;
  logic signed [OPERAND_WIDTH-1:0] m_l, m_r;
  logic signed [PW-1:0] prod;
  logic [ValueWidth-1:0] e0, e1, e2;
  logic bad;

  assign in_ready_o = (state_q == FIdle);

  // Classify the incoming item
  always_comb begin
    bad = (in_i.den_a[OPERAND_WIDTH-1:0] == '0) || (in_i.den_b[OPERAND_WIDTH-1:0] == '0) ||
          ((action_e'(in_i.action) == ActDiv) && (in_i.num_b[OPERAND_WIDTH-1:0] == '0));
  end

  // Select the operand pair for the shared multiplier
  always_comb begin
    unique case (step_q)
      2'd0: begin
        m_l = a_q;
        m_r = (act_q == ActMul) ? c_q : d_q;
      end
      2'd1: begin
        m_l = c_q;
        m_r = b_q;
      end
      default: begin
        m_l = b_q;
        m_r = (act_q == ActDiv) ? c_q : d_q;
      end
    endcase
    prod = m_l * m_r;
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      FIdle: begin
        if (in_valid_i) begin
          state_d = bad ? FPush : FMul;
          step_d  = 2'd0;
        end
      end
      FMul: begin
        step_d = step_q + 2'd1;
        if (step_q == 2'd2) state_d = FPush;
      end
      FPush: begin
        if (job_ready_i) state_d = FIdle;
      end
      default: state_d = FIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FIdle;
      step_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Hold the operands and products
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      a_q   <= in_i.num_a[OPERAND_WIDTH-1:0];
      b_q   <= in_i.den_a[OPERAND_WIDTH-1:0];
      c_q   <= in_i.num_b[OPERAND_WIDTH-1:0];
      d_q   <= in_i.den_b[OPERAND_WIDTH-1:0];
      act_q <= action_e'(in_i.action);
      err_q <= bad;
    end
    if (state_q == FMul) begin
      unique case (step_q)
        2'd0:    p0_q <= prod;
        2'd1:    p1_q <= prod;
        default: p2_q <= prod;
      endcase
    end
  end

  // Form numerator and denominator
  always_comb begin
    e0 = ValueWidth'(p0_q);
    e1 = ValueWidth'(p1_q);
    e2 = ValueWidth'(p2_q);
    job_o.err = err_q;
    job_o.y   = err_q ? '0 : e2;
    unique case (act_q)
      ActAdd:  job_o.x = e0 + e1;
      ActSub:  job_o.x = e0 - e1;
      default: job_o.x = e0;
    endcase
    if (err_q) job_o.x = '0;
  end

  assign job_valid_o = (state_q == FPush);

endmodule

// ----- rtl/core/rfa_queue.sv -----
`timescale 1ns / 1ps
module rfa_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  rfa_pkg::job_t wr_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output rfa_pkg::job_t rd_o
);
  import rfa_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  job_t mem_q [QueueDepth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [CntW-1:0] cnt_q;
  logic push, pop;

  assign wr_ready_o = (cnt_q != CntW'(QueueDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign push = wr_valid_i && wr_ready_o;
  assign pop  = rd_valid_o && rd_ready_i;
  assign rd_o = mem_q[rp_q];

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= (wp_q == PtrW'(QueueDepth - 1)) ? '0 : wp_q + 1'b1;
      if (pop)  rp_q <= (rp_q == PtrW'(QueueDepth - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + CntW'(push) - CntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= wr_i;
  end

endmodule

// ----- rtl/core/rfa_div.sv -----
`timescale 1ns / 1ps
module rfa_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [rfa_pkg::ValueWidth-1:0] dividend_i,
  input  logic [rfa_pkg::ValueWidth-1:0] divisor_i,
  output rfa_pkg::div_rsp_t              rsp_o
);
  import rfa_pkg::*;

  localparam int CntW = $clog2(ValueWidth);

  logic busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [ValueWidth-1:0] rem_q, quo_q, dsr_q;
  logic [ValueWidth:0] shifted, trial;

  // One quotient bit per cycle, restoring
  always_comb begin
    shifted = {rem_q, quo_q[ValueWidth-1]};
    trial   = shifted - {1'b0, dsr_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(ValueWidth - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end else if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      rem_q <= trial[ValueWidth] ? shifted[ValueWidth-1:0] : trial[ValueWidth-1:0];
      quo_q <= {quo_q[ValueWidth-2:0], ~trial[ValueWidth]};
    end else if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ----- rtl/core/rfa_back.sv -----
`timescale 1ns / 1ps
module rfa_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  output logic          job_ready_o,
  input  rfa_pkg::job_t job_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rfa_pkg::out_t out_o
);
  import rfa_pkg::*;

  typedef enum logic [4:0] {
    BIdle = 5'b00001,
    BGcd  = 5'b00010,
    BRem  = 5'b00100,
    BDivX = 5'b01000,
    BDivY = 5'b10000
  } bstate_e;

  bstate_e state_q, state_d;
  logic [ValueWidth-1:0] x_q, y_q, ox_q, oy_q, rnum_q;
  logic out_valid_q;
  out_t out_q;
  logic start;
  logic [ValueWidth-1:0] dvd, dsr;
  div_rsp_t rsp;

  rfa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .dividend_i (dvd),
    .divisor_i  (dsr),
    .rsp_o      (rsp)
  );

  assign job_ready_o = (state_q == BIdle) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // Sequence the Euclid loop and the two final divisions
  always_comb begin
    state_d = state_q;
    start   = 1'b0;
    dvd     = mag(x_q);
    dsr     = mag(y_q);
    unique case (state_q)
      BIdle: begin
        if (job_valid_i && job_ready_o && !job_i.err) state_d = BGcd;
      end
      BGcd: begin
        start = 1'b1;
        if (y_q == '0) begin
          dvd     = mag(ox_q);
          dsr     = mag(x_q);
          state_d = BDivX;
        end else begin
          state_d = BRem;
        end
      end
      BRem: begin
        if (rsp.done) state_d = BGcd;
      end
      BDivX: begin
        dvd = mag(oy_q);
        dsr = mag(x_q);
        if (rsp.done) begin
          start   = 1'b1;
          state_d = BDivY;
        end
      end
      BDivY: begin
        if (rsp.done) state_d = BIdle;
      end
      default: state_d = BIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end else if ((state_q == BIdle) && job_valid_i && job_ready_o && job_i.err) begin
        out_valid_q <= 1'b1;
      end else if ((state_q == BDivY) && rsp.done) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  // Hold the working pair and the result
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      BIdle: begin
        if (job_valid_i && job_ready_o) begin
          x_q  <= job_i.x;
          y_q  <= job_i.y;
          ox_q <= job_i.x;
          oy_q <= job_i.y;
          if (job_i.err) begin
            out_q.status     <= 1'b1;
            out_q.result_num <= '0;
            out_q.result_den <= '0;
          end
        end
      end
      BRem: begin
        if (rsp.done) begin
          y_q <= negate_if(x_q[ValueWidth-1], rsp.rem);
          x_q <= y_q;
        end
      end
      BDivX: begin
        if (rsp.done) rnum_q <= negate_if(ox_q[ValueWidth-1] ^ x_q[ValueWidth-1], rsp.quo);
      end
      BDivY: begin
        if (rsp.done) begin
          out_q.status     <= 1'b0;
          out_q.result_num <= rnum_q;
          out_q.result_den <= negate_if(oy_q[ValueWidth-1] ^ x_q[ValueWidth-1], rsp.quo);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- rtl/core/rational_fraction_alu.sv -----
`timescale 1ns / 1ps
// Operation: the front forms three products in turn on one shared multiplier; the back
// runs each Euclid remainder step and the two final divisions on one bit-serial divider.
// Overlap: the front takes a new item while the back works, with a two-entry queue
// between them. Error items skip the multiplier and the divider.
// Reset: rst_ni asynchronous, active low; clears all control state and the queue.
module rational_fraction_alu #(
  parameter int OPERAND_WIDTH = rfa_pkg::OperandWidth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rfa_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rfa_pkg::out_t out_o
);
  import rfa_pkg::*;

  logic f_valid, f_ready, q_valid, q_ready;
  job_t f_job, q_job;

  rfa_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .job_valid_o (f_valid),
    .job_ready_i (f_ready),
    .job_o       (f_job)
  );

  rfa_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f_valid),
    .wr_ready_o (f_ready),
    .wr_i       (f_job),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_o       (q_job)
  );

  rfa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_ready_o (q_ready),
    .job_i       (q_job),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import rfa_pkg::*;

  localparam int OW       = rfa_pkg::OperandWidth;
  localparam int RandTotal = 1400;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t  in_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_o;

  // Directed row: item, whether the expected result is typed in, and that result
  typedef struct {
    in_t  item;
    bit   typed;
    out_t res;
  } vec_t;

  out_t fraction_q[$];
  vec_t dir_tab[$];
  int   fail_cnt = 0;
  int   gap_pct = 0;
  int   stall_pct = 0;

  rational_fraction_alu #(.OPERAND_WIDTH(OW)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

  always #2 clk_i = ~clk_i;

  // Sign-extend an operand from its low OW bits
  function automatic logic [63:0] widen(input logic [31:0] f);
    logic [63:0] v;
    v = {32'd0, f};
    widen = $signed(v << (64 - OW)) >>> (64 - OW);
  endfunction

  function automatic logic [63:0] absval(input logic [63:0] v);
    absval = v[63] ? (64'd0 - v) : v;
  endfunction

  function automatic logic [63:0] trunc_mod(input logic [63:0] x, input logic [63:0] y);
    logic [63:0] r;
    r = absval(x) % absval(y);
    trunc_mod = x[63] ? (64'd0 - r) : r;
  endfunction

  function automatic logic [63:0] trunc_quo(input logic [63:0] x, input logic [63:0] y);
    logic [63:0] q;
    q = absval(x) / absval(y);
    trunc_quo = (x[63] != y[63]) ? (64'd0 - q) : q;
  endfunction

  // Reduced fraction for one item
  function automatic out_t reduce_fraction(input in_t it);
    logic [63:0] a, b, c, d, x, y, g, h, t;
    out_t r;
    a = widen(it.num_a);
    b = widen(it.den_a);
    c = widen(it.num_b);
    d = widen(it.den_b);
    r = '0;
    if (b == 0 || d == 0 || (action_e'(it.action) == ActDiv && c == 0)) begin
      r.status = 1'b1;
      return r;
    end
    case (action_e'(it.action))
      ActAdd: begin x = a * d + c * b; y = b * d; end
      ActSub: begin x = a * d - c * b; y = b * d; end
      ActMul: begin x = a * c; y = b * d; end
      default: begin x = a * d; y = b * c; end
    endcase
    g = x;
    h = y;
    while (h != 0) begin
      t = h;
      h = trunc_mod(g, h);
      g = t;
    end
    if (g == 0) begin
      r.status = 1'b1;
      return r;
    end
    r.result_num = trunc_quo(x, g);
    r.result_den = trunc_quo(y, g);
    return r;
  endfunction

  function automatic in_t mk(input action_e act, input logic [31:0] a, input logic [31:0] b,
                             input logic [31:0] c, input logic [31:0] d);
    in_t it;
    it.action = act;
    it.num_a = a;
    it.den_a = b;
    it.num_b = c;
    it.den_b = d;
    return it;
  endfunction

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0, 1: rand_operand = $urandom();
      2, 3: rand_operand = $urandom_range(0, 2000) - 1000;
      default: begin
        case ($urandom_range(0, 4))
          0: rand_operand = 32'h8000_0000;
          1: rand_operand = 32'h7fff_ffff;
          2: rand_operand = 32'hffff_ffff;
          3: rand_operand = 32'd1;
          default: rand_operand = 32'd0;
        endcase
      end
    endcase
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    fail_cnt++;
  endtask

  // Offer one item, hold it until accepted, then queue its expected result
  task automatic send(input in_t it, input out_t res);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_i = it;
    do @(posedge clk_i); while (!in_ready_o);
    fraction_q.push_back(res);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic drain();
    while (fraction_q.size() != 0) @(posedge clk_i);
  endtask

  // Receiver stall
  always @(negedge clk_i) out_ready_i <= ($urandom_range(0, 99) >= stall_pct);

  // Check each result against the oldest expectation
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (fraction_q.size() == 0) begin
        report("unexpected item", out_o.result_num, 64'd0);
      end else begin
        want = fraction_q.pop_front();
        if (out_o.status !== want.status)
          report("status", 64'(out_o.status), 64'(want.status));
        if (out_o.result_num !== want.result_num)
          report("result_num", out_o.result_num, want.result_num);
        if (out_o.result_den !== want.result_den)
          report("result_den", out_o.result_den, want.result_den);
      end
    end
  end

  initial begin
    out_t errres, zero_one;
    in_t  it;
    errres = '0;
    errres.status = 1'b1;
    zero_one = '0;
    zero_one.result_den = 64'd1;

    dir_tab.push_back('{mk(ActAdd, 1, 0, 1, 1), 1, errres});
    dir_tab.push_back('{mk(ActSub, 1, 1, 1, 0), 1, errres});
    dir_tab.push_back('{mk(ActMul, 5, 0, 7, 0), 1, errres});
    dir_tab.push_back('{mk(ActDiv, 3, 4, 0, 5), 1, errres});
    dir_tab.push_back('{mk(ActDiv, 3, 0, 2, 5), 1, errres});
    dir_tab.push_back('{mk(ActMul, 0, 7, 9, 3), 1, zero_one});
    dir_tab.push_back('{mk(ActAdd, 0, 5, 0, 9), 1, zero_one});
    dir_tab.push_back('{mk(ActSub, 3, 4, 3, 4), 1, zero_one});
    dir_tab.push_back('{mk(ActAdd, 1, 2, 1, 3), 0, errres});
    dir_tab.push_back('{mk(ActSub, 1, 2, 1, 3), 0, errres});
    dir_tab.push_back('{mk(ActMul, -6, 4, 2, -9), 0, errres});
    dir_tab.push_back('{mk(ActDiv, 6, 4, -2, 9), 0, errres});
    dir_tab.push_back('{mk(ActMul, 32'h8000_0000, 1, 32'h8000_0000, 1), 0, errres});
    dir_tab.push_back('{mk(ActAdd, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                          32'h8000_0000), 0, errres});
    dir_tab.push_back('{mk(ActSub, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                          32'h8000_0000), 0, errres});
    dir_tab.push_back('{mk(ActDiv, 32'h8000_0000, 32'hffff_ffff, 32'h8000_0000,
                          32'hffff_ffff), 0, errres});
    dir_tab.push_back('{mk(ActMul, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                          32'hffff_ffff), 0, errres});
    dir_tab.push_back('{mk(ActDiv, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                          32'h7fff_ffff), 0, errres});

    // Hold reset, then release
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Walk the directed table
    foreach (dir_tab[i]) begin
      it = dir_tab[i].item;
      send(it, dir_tab[i].typed ? dir_tab[i].res : reduce_fraction(it));
    end
    // Pause until every result is back
    drain();

    // Random phases: free run, sender gaps, receiver stalls, both
    for (int ph = 0; ph < 4; ph++) begin
      gap_pct   = (ph == 1) ? 84 : (ph == 3) ? 12 : 0;
      stall_pct = (ph == 2) ? 84 : (ph == 3) ? 12 : 0;
      for (int n = 0; n < RandTotal / 4; n++) begin
        it = mk(action_e'($urandom_range(0, 3)), rand_operand(), rand_operand(),
                rand_operand(), rand_operand());
        send(it, reduce_fraction(it));
      end
      drain();
    end

    repeat (300) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("** rational_fraction_alu: PASSED **");
    end else begin
      $display("** rational_fraction_alu: FAILED **");
    end
    $finish;
  end

  // Overall time limit
  initial begin
    #400_000_000;
    $display("** rational_fraction_alu: FAILED **");
    $finish;
  end

endmodule
